>>> rtl/iior_pkg.sv
// Shared types, constants and helpers of the ISA interrupt override router.
`default_nettype none

package iior_pkg;

	localparam int TABLE_DEPTH  = 16;
	localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int LINE_W       = 8;
	localparam int WORD_W       = 32;
	localparam int VECTOR_BASE  = 64;
	localparam int LEGACY_LINES = 16;

	localparam logic [CNT_W-1:0]  DEPTH_CNT     = CNT_W'(TABLE_DEPTH);
	localparam logic [LINE_W-1:0] VEC_BASE_C    = LINE_W'(VECTOR_BASE);
	localparam logic [LINE_W-1:0] LEGACY_LINE_C = LINE_W'(LEGACY_LINES);
	localparam logic [WORD_W-1:0] BIT_ACTIVE_LOW = 32'h0000_2000;
	localparam logic [WORD_W-1:0] BIT_LEVEL      = 32'h0000_8000;

	typedef enum logic {
		CMD_ADD     = 1'b0,
		CMD_RESOLVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_TAKEN   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [LINE_W-1:0] legacy;
		logic [LINE_W-1:0] target;
		logic              low;
		logic              level;
	} ovr_entry_t;

	// Low word of a redirection entry: vector in the low byte, polarity and trigger flags.
	function automatic logic [WORD_W-1:0] redir_word(input logic [LINE_W-1:0] legacy,
			input logic low, input logic level);
		logic [LINE_W-1:0] vec;
		logic [WORD_W-1:0] w;
		vec = legacy + VEC_BASE_C;
		w   = {{(WORD_W-LINE_W){1'b0}}, vec};
		if (low)
			w = w | BIT_ACTIVE_LOW;
		if (level)
			w = w | BIT_LEVEL;
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/iior_table.sv
// Override table storage: one write port, one registered read port.
`default_nettype none

module iior_table
	import iior_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire ovr_entry_t       wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output ovr_entry_t            rd_data
);

	ovr_entry_t mem_q [TABLE_DEPTH];
	ovr_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/isa_irq_override_router_top.sv
// ISA interrupt override router: override table with sequential route lookup.
// An add is handled in the add state and its result loads the output register in the finish state. A resolve
// scans the table one entry at a time (read, then compare) in up to two passes, legacy field
// then target field. Throughput: one item at a time; ready again in the cycle after the result
// loads into the output register, even while that result waits there.
// Reset clears the entry count, sequencer and output valid; table contents need no reset.
`default_nettype none

module isa_irq_override_router_top
	import iior_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire logic [LINE_W-1:0] legacy_line,
	input  wire logic [LINE_W-1:0] target_line,
	input  wire logic              active_low,
	input  wire logic              level_trig,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [LINE_W-1:0]      route_line,
	output logic [WORD_W-1:0]      redir_low
);

	// Control state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pass_q;
	logic              out_valid_q;

	// Latched request.
	cmd_t              cmd_q;
	logic [LINE_W-1:0] legacy_q;
	logic [LINE_W-1:0] target_q;
	logic              low_q;
	logic              level_q;

	// Pending result and output register.
	status_t           res_status_q;
	logic [LINE_W-1:0] res_line_q;
	logic [WORD_W-1:0] res_word_q;
	status_t           out_status_q;
	logic [LINE_W-1:0] out_line_q;
	logic [WORD_W-1:0] out_word_q;

	// Sequencer controls.
	logic              accept;
	logic              mem_we;
	logic              mem_re;
	logic              idx_clr;
	logic              idx_inc;
	logic              pass_set;
	logic              cnt_inc;
	logic              res_load;
	status_t           res_status_d;
	logic [LINE_W-1:0] res_line_d;
	logic [WORD_W-1:0] res_word_d;
	logic              out_load;

	// Shared compare unit.
	ovr_entry_t        rd_entry;
	ovr_entry_t        wr_entry;
	logic [LINE_W-1:0] cmp_key;
	logic              cmp_hit;
	logic              end_of_pass;
	logic              legacy_bad;
	logic              out_free;

	assign wr_entry = '{legacy: legacy_q, target: target_q, low: low_q, level: level_q};

	iior_table u_table (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_entry),
		.rd_en   (mem_re),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	// First pass looks for the legacy line; second pass looks for a claim on it.
	assign cmp_key     = pass_q ? rd_entry.target : rd_entry.legacy;
	assign cmp_hit     = (cmp_key == legacy_q);
	assign end_of_pass = (idx_q == count_q);
	assign legacy_bad  = (legacy_q >= LEGACY_LINE_C);
	assign out_free    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (cmd_t'(cmd) == CMD_ADD) ? S_ADD : S_SCAN_RD;
			end
			S_ADD: begin
				state_d = S_FIN;
			end
			S_SCAN_RD: begin
				if (end_of_pass && pass_q)
					state_d = S_FIN;
				else if (!end_of_pass)
					state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = cmp_hit ? S_FIN : S_SCAN_RD;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready     = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		idx_clr      = 1'b0;
		idx_inc      = 1'b0;
		pass_set     = 1'b0;
		cnt_inc      = 1'b0;
		res_load     = 1'b0;
		res_status_d = ST_OK;
		res_line_d   = '0;
		res_word_d   = '0;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				idx_clr  = 1'b1;
			end
			S_ADD: begin
				// Store in the next free slot unless the table is full.
				res_load = 1'b1;
				if (count_q == DEPTH_CNT) begin
					res_status_d = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			S_SCAN_RD: begin
				if (end_of_pass) begin
					if (pass_q) begin
						// No override and no claim: identity route, or invalid status for a line outside the legacy range.
						res_load = 1'b1;
						if (legacy_bad) begin
							res_status_d = ST_INVALID;
						end else begin
							res_line_d = legacy_q;
							res_word_d = redir_word(legacy_q, 1'b0, 1'b0);
						end
					end else begin
						pass_set = 1'b1;
						idx_clr  = 1'b1;
					end
				end else begin
					mem_re = 1'b1;
				end
			end
			S_SCAN_CMP: begin
				if (cmp_hit) begin
					res_load = 1'b1;
					if (pass_q) begin
						res_status_d = ST_TAKEN;
					end else if (legacy_bad) begin
						res_status_d = ST_INVALID;
					end else begin
						res_line_d = rd_entry.target;
						res_word_d = redir_word(legacy_q, rd_entry.low, rd_entry.level);
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_FIN: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc)
				count_q <= count_q + CNT_W'(1);
			if (idx_clr)
				idx_q <= '0;
			else if (idx_inc)
				idx_q <= idx_q + CNT_W'(1);
			if (accept)
				pass_q <= 1'b0;
			else if (pass_set)
				pass_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers: hold the request, the pending result and the output item.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(cmd);
			legacy_q <= legacy_line;
			target_q <= target_line;
			low_q    <= active_low;
			level_q  <= level_trig;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_line_q   <= res_line_d;
			res_word_q   <= res_word_d;
		end
		if (out_load) begin
			out_status_q <= (cmd_q == CMD_ADD) ? res_status_q : res_status_q;
			out_line_q   <= res_line_q;
			out_word_q   <= res_word_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign route_line = out_line_q;
	assign redir_low  = out_word_q;

endmodule

`default_nettype wire
